// File: hdl/rfcd_pkg.sv
// Shared types and constants of the ROI frame change detector.
package rfcd_pkg;

  // Sizing defaults
  localparam int MAX_ROI_WIDTH_DEF  = 256;
  localparam int MAX_ROI_HEIGHT_DEF = 256;
  localparam int MAX_FRAME_SIDE_DEF = 4096;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROI_LEFT   = 3'd0,
    REG_ROI_TOP    = 3'd1,
    REG_ROI_WIDTH  = 3'd2,
    REG_ROI_HEIGHT = 3'd3,
    REG_THRESHOLD  = 3'd4,
    REG_ROI_TAG    = 3'd5
  } cfg_reg_t;

  // Luma weights, Q14
  localparam logic [12:0] GRAY_KR   = 13'd4899;
  localparam logic [13:0] GRAY_KG   = 14'd9617;
  localparam logic [10:0] GRAY_KB   = 11'd1868;
  localparam logic [13:0] GRAY_RND  = 14'd8192;
  localparam int          GRAY_SHIFT = 14;

  // Window sums: column sum of 3 bytes, window sum of 9 bytes
  localparam int COLW = 10;
  localparam int SUMW = 12;

  // round(s/9) = (2s+9)/18 = ((2s+9)*3641) >> 16 for 2s+9 < 32768
  localparam logic [11:0] MEAN_RECIP = 12'd3641;
  localparam int          MEAN_SHIFT = 16;

  // Threshold compare: mean*100 >= thr*255
  localparam logic [6:0] PCT_SCALE  = 7'd100;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  // Per-pixel position flags carried down the pipeline
  typedef struct packed {
    logic vld;         // stage holds a word
    logic inroi;       // pixel lies in the rectangle
    logic row_ok;      // rectangle row >= 1
    logic row_second;  // rectangle row == 1
    logic row_last;    // last rectangle row
    logic col_ok;      // rectangle column >= 1
    logic col_second;  // rectangle column == 1
    logic col_last;    // last rectangle column
    logic eof;         // last pixel of the frame
    logic cmp;         // frame result is a real comparison
    logic [7:0] tag;   // rectangle tag at end of frame
  } pix_flags_t;

  // Frame summary leaving the window stage
  typedef struct packed {
    logic vld;
    logic cmp;
    logic [7:0] tag;
    logic [SUMW-1:0] sum;
  } frame_sum_t;

endpackage

// File: hdl/rfcd_pix_if.sv
// Pixel channel: valid/ready handshake with RGB and raster markers.
interface rfcd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       end_of_line;
  logic       end_of_frame;

  modport source(output valid, red, green, blue, end_of_line, end_of_frame, input ready);
  modport sink(input valid, red, green, blue, end_of_line, end_of_frame, output ready);
endinterface

// File: hdl/rfcd_res_if.sv
// Result channel: valid/ready handshake with the per-frame verdict.
interface rfcd_res_if;
  logic       valid;
  logic       ready;
  logic       changed;
  logic [7:0] peak_level;
  logic       compared;
  logic [7:0] rectangle_id;

  modport source(output valid, changed, peak_level, compared, rectangle_id, input ready);
  modport sink(input valid, changed, peak_level, compared, rectangle_id, output ready);
endinterface

// File: hdl/rfcd_window.sv
// Horizontal 3x3 window sums with mirrored edges and running peak of the frame.
module rfcd_window
  import rfcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  pix_flags_t       flags,
  input  logic [COLW-1:0]  col_a,   // column sum centered one row up
  input  logic [COLW-1:0]  col_b,   // column sum centered on last row
  output frame_sum_t       res
);

  logic [COLW-1:0] ha1_r, ha2_r, hb1_r, hb2_r;
  logic [SUMW-1:0] peak_r, peak_nxt;
  logic [SUMW-1:0] sa1, sa2, sb1, sb2;
  logic            act;
  frame_sum_t      res_r;

  assign act = flags.vld && flags.inroi && flags.row_ok;

  // Window sums; left neighbor of column 0 mirrors to column 1
  always_comb begin
    sa1 = SUMW'(flags.col_second ? col_a : ha2_r) + SUMW'(ha1_r) + SUMW'(col_a);
    sa2 = SUMW'({ha1_r, 1'b0}) + SUMW'(col_a);
    sb1 = SUMW'(flags.col_second ? col_b : hb2_r) + SUMW'(hb1_r) + SUMW'(col_b);
    sb2 = SUMW'({hb1_r, 1'b0}) + SUMW'(col_b);
  end

  // Peak update over the windows that complete at this pixel
  always_comb begin
    peak_nxt = peak_r;
    if (act && flags.col_ok) begin
      if (sa1 > peak_nxt) peak_nxt = sa1;
      if (flags.col_last && sa2 > peak_nxt) peak_nxt = sa2;
      if (flags.row_last && sb1 > peak_nxt) peak_nxt = sb1;
      if (flags.row_last && flags.col_last && sb2 > peak_nxt) peak_nxt = sb2;
    end
  end

  // Column history
  always_ff @(posedge clk) begin
    if (adv && act) begin
      ha2_r <= ha1_r;
      ha1_r <= col_a;
      hb2_r <= hb1_r;
      hb1_r <= col_b;
    end
  end

  // Peak and frame summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r    <= '0;
      res_r.vld <= 1'b0;
    end else if (adv) begin
      res_r.vld <= flags.vld && flags.eof;
      if (flags.vld && flags.eof) begin
        peak_r <= '0;
      end else begin
        peak_r <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.cmp <= flags.cmp;
      res_r.tag <= flags.tag;
      res_r.sum <= peak_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: hdl/roi_frame_change_detector_core.sv
// Top level of the ROI frame change detector.
//
// Pixels arrive on in_pix in raster order, one word per handshake, with
// end_of_line and end_of_frame marking the raster. One rectangle, set on the
// cfg_ port, is cropped, made gray and differenced against the stored gray
// of the previous frame; a 3x3 mirrored mean of the differences feeds a
// running peak. Each pixel carrying end_of_frame yields one result word on
// out_res; other pixels yield none.
// Throughput: one pixel per cycle while the pipe is not halted. The pipe has
// six register stages (input, gray/store read, difference/column sums,
// window/peak, mean, verdict) from the end-of-frame pixel to its result.
// The output register lets the pipe keep taking pixels while a result waits;
// the pipe halts only when a second result reaches the mean stage while the
// first is still not taken, and in_pix.ready then stays low.
// Reset clears configuration to defaults, the raster counters, the peak and
// the previous-frame flag; the first frame after reset or after a geometry
// write reports compared = 0. The frame stores need no clearing.
module roi_frame_change_detector_core
  import rfcd_pkg::*;
#(
  parameter int MAX_ROI_WIDTH  = MAX_ROI_WIDTH_DEF,
  parameter int MAX_ROI_HEIGHT = MAX_ROI_HEIGHT_DEF,
  parameter int MAX_FRAME_SIDE = MAX_FRAME_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rfcd_pix_if.sink              in_pix,
  rfcd_res_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EW   = $clog2(MAX_ROI_WIDTH + 1);
  localparam int HW   = $clog2(MAX_ROI_HEIGHT + 1);
  localparam int XW   = $clog2(MAX_ROI_WIDTH);
  localparam int YW   = $clog2(MAX_ROI_HEIGHT);
  localparam int AW   = XW + YW;
  localparam int PW   = $clog2(MAX_FRAME_SIDE + 1);
  localparam int CMPW = (PW > 13) ? PW + 1 : 14;
  localparam int CVW  = $clog2(MAX_ROI_WIDTH * MAX_ROI_HEIGHT + 1);

  // Configuration registers
  logic [11:0] roi_left_r, roi_top_r;
  logic [8:0]  roi_width_r, roi_height_r;
  logic [6:0]  thr_r;
  logic [7:0]  tag_r;

  // Raster state
  logic [PW-1:0]  col_r, row_r;
  logic [CVW-1:0] covered_r;
  logic           have_prev_r;

  logic [EW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;
  logic [CVW-1:0]  area;
  logic [CMPW-1:0] col_x, row_x, left_x, top_x, right_x, bottom_x;
  logic            inroi;
  logic [XW-1:0]   rel_x;
  logic [YW-1:0]   rel_y;
  logic            complete, accept, adv, geom_wr;
  pix_flags_t      f0;

  // Pipeline registers
  pix_flags_t      s1_r, s2_r, s3_r;
  logic [XW-1:0]   s1_x_r, s2_x_r;
  logic [YW-1:0]   s1_y_r, s2_y_r;
  logic [7:0]      s1_red_r, s1_green_r, s1_blue_r;
  logic [7:0]      gray2_r, prev_rd_r;
  logic [15:0]     line_rd_r;
  logic [COLW-1:0] col_a3_r, col_b3_r;
  frame_sum_t      s4;
  logic            s5_vld_r, s5_cmp_r;
  logic [7:0]      s5_tag_r, s5_mean_r;
  logic            out_vld_r, out_changed_r, out_compared_r;
  logic [7:0]      out_peak_r, out_tag_r;

  logic [7:0]  prev_mem [2**AW];
  logic [15:0] line_mem [2**XW];

  logic [23:0]     gray_acc;
  logic [7:0]      diff2, d_old, d_new, top2;
  logic [12:0]     mean_in;
  logic [24:0]     mean_prod;
  logic [14:0]     lhs, rhs;

  // Effective rectangle size, saturated
  always_comb begin
    if (32'(roi_width_r) > MAX_ROI_WIDTH) eff_w = EW'(MAX_ROI_WIDTH);
    else if (roi_width_r < 9'd2)          eff_w = EW'(2);
    else                                  eff_w = EW'(roi_width_r);
    if (32'(roi_height_r) > MAX_ROI_HEIGHT) eff_h = HW'(MAX_ROI_HEIGHT);
    else if (roi_height_r < 9'd2)           eff_h = HW'(2);
    else                                    eff_h = HW'(roi_height_r);
  end

  assign area = CVW'(eff_w * eff_h);

  // Rectangle hit test on the incoming pixel
  always_comb begin
    col_x    = CMPW'(col_r);
    row_x    = CMPW'(row_r);
    left_x   = CMPW'(roi_left_r);
    top_x    = CMPW'(roi_top_r);
    right_x  = left_x + CMPW'(eff_w);
    bottom_x = top_x + CMPW'(eff_h);
    inroi    = (32'(col_r) < MAX_FRAME_SIDE) && (32'(row_r) < MAX_FRAME_SIDE) &&
               (col_x >= left_x) && (col_x < right_x) &&
               (row_x >= top_x) && (row_x < bottom_x);
    rel_x    = XW'(col_x - left_x);
    rel_y    = YW'(row_x - top_x);
    complete = (covered_r + CVW'(inroi)) == area;
  end

  always_comb begin
    f0.vld        = accept;
    f0.inroi      = inroi;
    f0.row_ok     = rel_y != '0;
    f0.row_second = CMPW'(rel_y) == CMPW'(1);
    f0.row_last   = CMPW'(rel_y) == CMPW'(eff_h) - CMPW'(1);
    f0.col_ok     = rel_x != '0;
    f0.col_second = CMPW'(rel_x) == CMPW'(1);
    f0.col_last   = CMPW'(rel_x) == CMPW'(eff_w) - CMPW'(1);
    f0.eof        = in_pix.end_of_frame;
    f0.cmp        = complete && have_prev_r;
    f0.tag        = tag_r;
  end

  // Handshake: the pipe halts only on a result blocked behind a full output
  assign adv          = !(s5_vld_r && out_vld_r && !out_res.ready);
  assign in_pix.ready = adv;
  assign accept       = in_pix.valid && adv;
  assign geom_wr      = cfg_we && ((cfg_index == REG_ROI_LEFT) || (cfg_index == REG_ROI_TOP) ||
                        (cfg_index == REG_ROI_WIDTH) || (cfg_index == REG_ROI_HEIGHT));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_left_r   <= '0;
      roi_top_r    <= '0;
      roi_width_r  <= 9'd256;
      roi_height_r <= 9'd256;
      thr_r        <= 7'd10;
      tag_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROI_LEFT:   roi_left_r   <= cfg_data[11:0];
        REG_ROI_TOP:    roi_top_r    <= cfg_data[11:0];
        REG_ROI_WIDTH:  roi_width_r  <= cfg_data[8:0];
        REG_ROI_HEIGHT: roi_height_r <= cfg_data[8:0];
        REG_THRESHOLD:  thr_r        <= cfg_data[6:0];
        REG_ROI_TAG:    tag_r        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Raster position, coverage and previous-frame flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      covered_r   <= '0;
      have_prev_r <= 1'b0;
    end else if (geom_wr) begin
      covered_r   <= '0;
      have_prev_r <= 1'b0;
    end else if (accept) begin
      if (in_pix.end_of_frame) begin
        col_r       <= '0;
        row_r       <= '0;
        covered_r   <= '0;
        have_prev_r <= complete;
      end else begin
        if (inroi) covered_r <= covered_r + CVW'(1);
        if (in_pix.end_of_line) begin
          col_r <= '0;
          if (32'(row_r) < MAX_FRAME_SIDE) row_r <= row_r + PW'(1);
        end else if (32'(col_r) < MAX_FRAME_SIDE) begin
          col_r <= col_r + PW'(1);
        end
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s1_r.vld <= f0.vld;
      s2_r.vld <= s1_r.vld;
      s3_r.vld <= s2_r.vld;
      s5_vld_r <= s4.vld;
    end
  end

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (adv) begin
      {s1_r.inroi, s1_r.row_ok, s1_r.row_second, s1_r.row_last, s1_r.col_ok,
       s1_r.col_second, s1_r.col_last, s1_r.eof, s1_r.cmp, s1_r.tag} <=
        {f0.inroi, f0.row_ok, f0.row_second, f0.row_last, f0.col_ok,
         f0.col_second, f0.col_last, f0.eof, f0.cmp, f0.tag};
      s1_x_r     <= rel_x;
      s1_y_r     <= rel_y;
      s1_red_r   <= in_pix.red;
      s1_green_r <= in_pix.green;
      s1_blue_r  <= in_pix.blue;
    end
  end

  // Stage 2: gray, previous gray and line pair reads
  assign gray_acc = 24'(s1_red_r * GRAY_KR) + 24'(s1_green_r * GRAY_KG) +
                    24'(s1_blue_r * GRAY_KB) + 24'(GRAY_RND);

  always_ff @(posedge clk) begin
    if (adv) begin
      {s2_r.inroi, s2_r.row_ok, s2_r.row_second, s2_r.row_last, s2_r.col_ok,
       s2_r.col_second, s2_r.col_last, s2_r.eof, s2_r.cmp, s2_r.tag} <=
        {s1_r.inroi, s1_r.row_ok, s1_r.row_second, s1_r.row_last, s1_r.col_ok,
         s1_r.col_second, s1_r.col_last, s1_r.eof, s1_r.cmp, s1_r.tag};
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      gray2_r   <= gray_acc[GRAY_SHIFT +: 8];
      prev_rd_r <= prev_mem[{s1_y_r, s1_x_r}];
      line_rd_r <= line_mem[s1_x_r];
    end
  end

  // Stage 3: difference, store writes, vertical column sums
  always_comb begin
    diff2 = (gray2_r > prev_rd_r) ? gray2_r - prev_rd_r : prev_rd_r - gray2_r;
    d_old = line_rd_r[15:8];
    d_new = line_rd_r[7:0];
    top2  = s2_r.row_second ? diff2 : d_old;
  end

  always_ff @(posedge clk) begin
    if (adv && s2_r.vld && s2_r.inroi) begin
      prev_mem[{s2_y_r, s2_x_r}] <= gray2_r;
      line_mem[s2_x_r]           <= {d_new, diff2};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {s3_r.inroi, s3_r.row_ok, s3_r.row_second, s3_r.row_last, s3_r.col_ok,
       s3_r.col_second, s3_r.col_last, s3_r.eof, s3_r.cmp, s3_r.tag} <=
        {s2_r.inroi, s2_r.row_ok, s2_r.row_second, s2_r.row_last, s2_r.col_ok,
         s2_r.col_second, s2_r.col_last, s2_r.eof, s2_r.cmp, s2_r.tag};
      col_a3_r <= COLW'(top2) + COLW'(d_new) + COLW'(diff2);
      col_b3_r <= COLW'({d_new, 1'b0}) + COLW'(diff2);
    end
  end

  // Stage 4: window sums and frame peak
  rfcd_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .flags (s3_r),
    .col_a (col_a3_r),
    .col_b (col_b3_r),
    .res   (s4)
  );

  // Stage 5: rounded mean of the peak window
  assign mean_in   = 13'({s4.sum, 1'b0}) + 13'd9;
  assign mean_prod = 25'(mean_in * MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_cmp_r  <= s4.cmp;
      s5_tag_r  <= s4.tag;
      s5_mean_r <= s4.cmp ? mean_prod[MEAN_SHIFT +: 8] : 8'd0;
    end
  end

  // Output register: threshold verdict
  assign lhs = 15'(s5_mean_r * PCT_SCALE);
  assign rhs = 15'(thr_r * FULL_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s5_vld_r && adv) begin
      out_vld_r <= 1'b1;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_vld_r && adv) begin
      out_changed_r  <= s5_cmp_r && (lhs >= rhs);
      out_peak_r     <= s5_mean_r;
      out_compared_r <= s5_cmp_r;
      out_tag_r      <= s5_tag_r;
    end
  end

  assign out_res.valid        = out_vld_r;
  assign out_res.changed      = out_changed_r;
  assign out_res.peak_level   = out_peak_r;
  assign out_res.compared     = out_compared_r;
  assign out_res.rectangle_id = out_tag_r;

endmodule

// File: hdl/rfcd_checker.sv
// Port-level checks of the change detector, bound to the top level.
module rfcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       changed,
  input logic [7:0] peak_level,
  input logic       compared,
  input logic [7:0] rectangle_id
);

  // A held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(changed) && $stable(peak_level) &&
    $stable(compared) && $stable(rectangle_id))
    else $error("result word changed while stalled");

  // Input stalls only behind a blocked result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // Without a comparison there is no change and no peak
  a_no_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !compared |-> !changed && peak_level == 8'd0)
    else $error("uncompared frame reports a level");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind roi_frame_change_detector_core rfcd_checker u_rfcd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_pix.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .changed      (out_res.changed),
  .peak_level   (out_res.peak_level),
  .compared     (out_res.compared),
  .rectangle_id (out_res.rectangle_id)
);

// File: tb/roi_frame_change_detector_core_test.sv
// Self-checking testbench for roi_frame_change_detector_core: frames in, per-frame verdicts checked.
module roi_frame_change_detector_core_test
  import rfcd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROI_W_MAX   = 256;
  localparam int ROI_H_MAX   = 256;
  localparam int FRAME_SIDE  = 4096;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_GAP   = 12;
  localparam int SCENE_SIDE  = 64;
  // indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // Predicts the per-frame verdict and holds verdicts not yet seen
  class change_scoreboard;
    typedef struct {
      bit       changed;
      bit [7:0] peak_level;
      bit       compared;
      bit [7:0] rectangle_id;
    } verdict_t;

    bit [11:0] left, top;
    bit [8:0]  width, height;
    bit [6:0]  thr_pct;
    bit [7:0]  tag;
    byte unsigned prev_gray[ROI_W_MAX*ROI_H_MAX];
    byte unsigned diff_img[ROI_W_MAX*ROI_H_MAX];
    bit        have_prev;
    int        col, row, covered;
    verdict_t  verdict_q[$];
    int        errors, frames, compared_n, changed_n;

    function new();
      left = 0; top = 0; width = 256; height = 256; thr_pct = 10; tag = 0;
      have_prev = 0; col = 0; row = 0; covered = 0;
      errors = 0; frames = 0; compared_n = 0; changed_n = 0;
      foreach (prev_gray[i]) prev_gray[i] = 0;
      foreach (diff_img[i]) diff_img[i] = 0;
    endfunction

    function int eff_w();
      return (width < 2) ? 2 : (width > ROI_W_MAX) ? ROI_W_MAX : int'(width);
    endfunction

    function int eff_h();
      return (height < 2) ? 2 : (height > ROI_H_MAX) ? ROI_H_MAX : int'(height);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ROI_LEFT:   left   = d;
        REG_ROI_TOP:    top    = d;
        REG_ROI_WIDTH:  width  = d[8:0];
        REG_ROI_HEIGHT: height = d[8:0];
        REG_THRESHOLD:  thr_pct = d[6:0];
        REG_ROI_TAG:    tag    = d[7:0];
        default: ;
      endcase
      // geometry writes restart the comparison
      if (idx inside {REG_ROI_LEFT, REG_ROI_TOP, REG_ROI_WIDTH, REG_ROI_HEIGHT}) begin
        have_prev = 0;
        covered = 0;
      end
    endfunction

    function int mirror_idx(int i, int n);
      if (i < 0) return 1;
      if (i >= n) return n - 2;
      return i;
    endfunction

    // largest rounded 3x3 mean over the difference image
    function int window_peak(int w, int h);
      int pk, sum, mean;
      pk = 0;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          sum = 0;
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              sum += diff_img[mirror_idx(y + dy, h) * ROI_W_MAX + mirror_idx(x + dx, w)];
          mean = (2 * sum + 9) / 18;
          if (mean > pk) pk = mean;
        end
      end
      return pk;
    endfunction

    function void note_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit eol, bit eof);
      int w, h, idx, gray, prv, pk;
      bit full, cmp;
      verdict_t v;
      w = eff_w();
      h = eff_h();
      if (col < FRAME_SIDE && row < FRAME_SIDE && col >= left && col < left + w &&
          row >= top && row < top + h) begin
        idx  = (row - top) * ROI_W_MAX + (col - left);
        gray = (4899 * r + 9617 * g + 1868 * b + 8192) >> 14;
        prv  = prev_gray[idx];
        diff_img[idx]  = (gray > prv) ? gray - prv : prv - gray;
        prev_gray[idx] = gray;
        covered++;
      end
      if (eof) begin
        full = (covered == w * h);
        cmp  = full && have_prev;
        pk   = cmp ? window_peak(w, h) : 0;
        v.changed      = cmp && (pk * 100 >= thr_pct * 255);
        v.peak_level   = pk;
        v.compared     = cmp;
        v.rectangle_id = tag;
        verdict_q.push_back(v);
        have_prev = full;
        col = 0; row = 0; covered = 0;
      end else if (eol) begin
        col = 0;
        if (row < FRAME_SIDE) row++;
      end else if (col < FRAME_SIDE) begin
        col++;
      end
    endfunction

    function void check(bit ch, bit [7:0] pk, bit cmp, bit [7:0] id);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("verdict word with nothing expected");
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      frames++;
      if (v.compared) compared_n++;
      if (v.changed) changed_n++;
      if (ch !== v.changed) begin
        $error("changed: expected %0d, got %0d", v.changed, ch); errors++;
      end
      if (pk !== v.peak_level) begin
        $error("peak_level: expected %0d, got %0d", v.peak_level, pk); errors++;
      end
      if (cmp !== v.compared) begin
        $error("compared: expected %0d, got %0d", v.compared, cmp); errors++;
      end
      if (id !== v.rectangle_id) begin
        $error("rectangle_id: expected %0d, got %0d", v.rectangle_id, id); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit   no_idle;
  int   stall_count;
  bit [23:0] scene[SCENE_SIDE*SCENE_SIDE];

  rfcd_pix_if pix ();
  rfcd_res_if res ();
  change_scoreboard sb;

  roi_frame_change_detector_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix),
    .out_res  (res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  initial res.ready = 0;
  always @(negedge clk) begin
    res.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 31);
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (pix.valid && pix.ready)
        sb.note_pixel(pix.red, pix.green, pix.blue, pix.end_of_line, pix.end_of_frame);
      if (res.valid && res.ready)
        sb.check(res.changed, res.peak_level, res.compared, res.rectangle_id);
      if ((pix.valid && pix.ready) || (res.valid && res.ready))
        stall_count <= 0;
      else
        stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("roi_frame_change_detector_core_test failed");
        $finish;
      end
    end
  end

  task automatic put_pixel(bit [23:0] rgb, bit eol, bit eof);
    while (!no_idle && $urandom_range(99) < 31) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid        <= 1'b1;
    pix.red          <= rgb[23:16];
    pix.green        <= rgb[15:8];
    pix.blue         <= rgb[7:0];
    pix.end_of_line  <= eol;
    pix.end_of_frame <= eof;
    do @(posedge clk); while (!pix.ready);
    @(negedge clk);
  endtask

  // wait until every verdict is in and the pipe has emptied
  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic set_roi(int l, int t, int w, int h, int thr, int tg);
    wait_idle();
    write_reg(REG_ROI_LEFT, l);
    write_reg(REG_ROI_TOP, t);
    write_reg(REG_ROI_WIDTH, w);
    write_reg(REG_ROI_HEIGHT, h);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_ROI_TAG, tg);
  endtask

  // re-randomize some of the scene, or all of it when churn < 0
  task automatic churn_scene(int churn);
    if (churn < 0)
      foreach (scene[i]) scene[i] = $urandom;
    else
      repeat (churn) scene[$urandom_range(SCENE_SIDE*SCENE_SIDE-1)] = $urandom;
  endtask

  // one raster frame; cut > 0 ends it early at that pixel
  task automatic send_frame(int cols, int rows, int cut = 0);
    int n;
    bit [23:0] rgb;
    bit last;
    n = 0;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        n++;
        if (x < SCENE_SIDE && y < SCENE_SIDE) rgb = scene[y*SCENE_SIDE + x];
        else rgb = $urandom;
        last = (cut > 0) ? (n == cut) : (y == rows - 1 && x == cols - 1);
        put_pixel(rgb, (x == cols - 1) || (last && $urandom_range(1)), last);
        if (last) return;
      end
    end
  endtask

  initial begin
    int l, t, w, h, cols, rows;
    sb = new();
    no_idle   = 0;
    cfg_we    = 0;
    cfg_index = REG_ROI_LEFT;
    cfg_data  = 0;
    pix.valid = 0;
    pix.red = 0; pix.green = 0; pix.blue = 0;
    pix.end_of_line = 0; pix.end_of_frame = 0;
    stall_count = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(negedge clk);

    // reset geometry is 256x256, so a small frame leaves it uncovered
    churn_scene(-1);
    send_frame(4, 3);

    // first frame, then identical frame at zero threshold
    set_roi(1, 1, 3, 3, 0, 8'hA5);
    send_frame(5, 5);
    send_frame(5, 5);
    // black to white at full threshold
    wait_idle();
    write_reg(REG_THRESHOLD, 100);
    foreach (scene[i]) scene[i] = 24'h000000;
    send_frame(5, 5);
    foreach (scene[i]) scene[i] = 24'hFFFFFF;
    send_frame(5, 5);
    // tag, threshold and spare indexes keep the previous frame
    wait_idle();
    write_reg(REG_ROI_TAG, 8'h5A);
    write_reg(REG_THRESHOLD, 127);
    write_reg(REG_SPARE_A, 12'hFFF);
    write_reg(REG_SPARE_B, 12'h000);
    send_frame(5, 5);
    // frame ending before the rectangle is complete
    send_frame(5, 5, 7);
    send_frame(5, 5);

    // sizes below the minimum saturate to 2
    set_roi(0, 0, 0, 1, 0, 8'hFF);
    churn_scene(-1);
    send_frame(3, 3);
    churn_scene(2);
    send_frame(3, 3);
    // corner beyond reach: never covered
    set_roi(4095, 4095, 2, 2, 10, 6);
    send_frame(3, 3);

    // random frames over random small rectangles
    for (int f = 0; f < 14; f++) begin
      no_idle = (f >= 4 && f < 10);
      if (f == 3) wait_idle();
      if (f == 0 || $urandom_range(3) == 0) begin
        l = $urandom_range(2);
        t = $urandom_range(1);
        w = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2, 5);
        h = ($urandom_range(9) == 0) ? $urandom_range(5) : $urandom_range(2, 4);
        set_roi(l, t, w, h, ($urandom_range(3) == 0) ? $urandom_range(127)
                                                     : $urandom_range(15),
                $urandom_range(255));
      end
      cols = l + ((w < 2) ? 2 : w) + $urandom_range(1);
      rows = t + ((h < 2) ? 2 : h) + $urandom_range(1);
      case ($urandom_range(9))
        0:       churn_scene(-1);
        1, 2:    churn_scene(0);
        default: churn_scene($urandom_range(1, 6));
      endcase
      if ($urandom_range(9) == 0) send_frame(cols, rows, $urandom_range(1, cols * rows));
      else send_frame(cols, rows);
    end

    no_idle = 0;
    wait_idle();
    repeat (DRAIN_GAP) @(negedge clk);
    $display("%0d frame verdicts checked: %0d compared, %0d reported change",
             sb.frames, sb.compared_n, sb.changed_n);
    $display("covered undersized and unreachable rectangles, cut frames, thresholds 0..127");
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("roi_frame_change_detector_core_test passed");
    end else begin
      $display("roi_frame_change_detector_core_test failed");
    end
    $finish;
  end
endmodule
